### rtl/cmsd_pkg.sv
// shared types, constants and codes for the multisynth divider calculator
// no dependencies
`timescale 1ns / 1ps
package cmsd_pkg;

    localparam int OUTPUT_SLOTS_DEF = 8;

    localparam int XTAL_W = 27;
    localparam int FREQ_W = 28;
    localparam int VCO_W  = 30;
    localparam int DEN_W  = 28;
    localparam int QUO_W  = 30;
    localparam int FRAC_W = 20;

    localparam logic [VCO_W-1:0]  VCO_MAX      = 30'd900000000;
    localparam logic [VCO_W-1:0]  VCO_RESET    = 30'd900000000;
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 28'd225000000;
    localparam logic [FREQ_W-1:0] FREQ_GAP_TOP = 28'd150000000;
    localparam logic [XTAL_W-1:0] XTAL_RESET   = 27'd25000000;
    localparam logic [3:0]        COUNT_RESET  = 4'd8;
    localparam logic [20:0]       FRAC_DEN     = 21'd1048575;
    localparam logic [17:0]       P1_MAX       = 18'd262143;
    localparam logic [19:0]       P1_OFFSET    = 20'd512;
    localparam logic [QUO_W-1:0]  A_LIMIT      = 30'd4096;
    localparam logic [6:0]        BASE_REG     = 7'd42;

    localparam logic [1:0] CFG_CRYSTAL = 2'd0;
    localparam logic [1:0] CFG_OUTPUTS = 2'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OUT   = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_BAD_DIV   = 3'd3;
    localparam logic [2:0] ST_GAP       = 3'd4;

    localparam logic [1:0] DIV4_ON      = 2'd3;

    typedef enum logic [1:0] {
        VC_IDLE,
        VC_DIVIDE,
        VC_SCALE
    } vco_state_t;

    typedef struct packed {
        logic [2:0]  output_index;
        logic [27:0] target_frequency;
        logic [7:0]  output_divider;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        use_pll_b;
        logic [6:0]  register_base;
        logic [17:0] ms_p1;
        logic [19:0] ms_p2;
        logic [19:0] ms_p3;
        logic [2:0]  r_div_code;
        logic [1:0]  div4_mode;
        logic [17:0] pll_p1;
        logic [19:0] pll_p2;
    } res_t;

    typedef struct packed {
        logic [2:0] status;
        logic       use_pll_b;
        logic [6:0] register_base;
        logic [2:0] r_div_code;
        logic [1:0] div4_mode;
    } meta_t;

    typedef struct packed {
        logic [QUO_W-1:0] a;
        meta_t            meta;
    } frac_side_t;

endpackage

### rtl/cmsd_div_pipe.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on nothing but its parameters
`timescale 1ns / 1ps
module cmsd_div_pipe #(
    parameter int STEPS  = 30,
    parameter int DEN_W  = 28,
    parameter int SIDE_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [STEPS-1:0]  in_bits,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STEPS-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic [STEPS-1:0]  v_reg;
    logic [DEN_W-1:0]  rem_reg  [STEPS];
    logic [STEPS-1:0]  bits_reg [STEPS];
    logic [DEN_W-1:0]  den_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [STEPS-1:0]  en;

    logic [STEPS-1:0]  src_v;
    logic [DEN_W-1:0]  src_rem  [STEPS];
    logic [STEPS-1:0]  src_bits [STEPS];
    logic [DEN_W-1:0]  src_den  [STEPS];
    logic [SIDE_W-1:0] src_side [STEPS];
    logic [DEN_W-1:0]  rem_next [STEPS];
    logic [STEPS-1:0]  bits_next [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_stage
            if (i == 0) begin : g_first
                assign src_v[i]    = in_valid;
                assign src_rem[i]  = in_rem;
                assign src_bits[i] = in_bits;
                assign src_den[i]  = in_den;
                assign src_side[i] = in_side;
            end else begin : g_next
                assign src_v[i]    = v_reg[i-1];
                assign src_rem[i]  = rem_reg[i-1];
                assign src_bits[i] = bits_reg[i-1];
                assign src_den[i]  = den_reg[i-1];
                assign src_side[i] = side_reg[i-1];
            end

            if (i == STEPS - 1) begin : g_last_en
                assign en[i] = !v_reg[i] || out_ready;
            end else begin : g_mid_en
                assign en[i] = !v_reg[i] || en[i+1];
            end

            always_comb begin
                logic [DEN_W:0] trial;
                logic           ge;
                trial = {src_rem[i], src_bits[i][STEPS-1]};
                ge    = trial >= {1'b0, src_den[i]};
                rem_next[i]  = ge ? DEN_W'(trial - {1'b0, src_den[i]}) : DEN_W'(trial);
                bits_next[i] = {src_bits[i][STEPS-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en[i]) begin
                    v_reg[i] <= src_v[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en[i]) begin
                    rem_reg[i]  <= rem_next[i];
                    bits_reg[i] <= bits_next[i];
                    den_reg[i]  <= src_den[i];
                    side_reg[i] <= src_side[i];
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = v_reg[STEPS-1];
    assign out_quo   = bits_reg[STEPS-1];
    assign out_rem   = rem_reg[STEPS-1];
    assign out_den   = den_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

### rtl/cmsd_vco_calc.sv
// sequential vco rate calculation after a crystal register write
// depends on cmsd_pkg
`timescale 1ns / 1ps
module cmsd_vco_calc (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cmsd_pkg::XTAL_W-1:0] xtal,
    output logic                      busy,
    output logic [cmsd_pkg::VCO_W-1:0]  vco
);

    cmsd_pkg::vco_state_t state_reg, state_next;
    logic [cmsd_pkg::XTAL_W-1:0] xtal_reg, xtal_next;
    logic [cmsd_pkg::XTAL_W-1:0] rem_reg, rem_next;
    logic [cmsd_pkg::VCO_W-1:0]  num_reg, num_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [cmsd_pkg::VCO_W-1:0]  vco_reg, vco_next;
    logic [cmsd_pkg::XTAL_W:0]   trial;
    logic                        ge;
    logic [56:0]                 prod;

    assign trial = {rem_reg, num_reg[cmsd_pkg::VCO_W-1]};
    assign ge    = trial >= {1'b0, xtal_reg};
    assign prod  = xtal_reg * {num_reg[cmsd_pkg::VCO_W-1:1], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cmsd_pkg::VC_IDLE;
            vco_reg   <= cmsd_pkg::VCO_RESET;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            vco_reg   <= vco_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        xtal_reg <= xtal_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
    end

    always_comb begin
        state_next = state_reg;
        xtal_next  = xtal_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        cnt_next   = cnt_reg;
        vco_next   = vco_reg;
        if (start) begin
            state_next = cmsd_pkg::VC_DIVIDE;
            xtal_next  = xtal;
            rem_next   = '0;
            num_next   = cmsd_pkg::VCO_MAX;
            cnt_next   = '0;
        end else begin
            unique case (state_reg)
                cmsd_pkg::VC_IDLE: begin
                end
                cmsd_pkg::VC_DIVIDE: begin
                    rem_next = ge ? cmsd_pkg::XTAL_W'(trial - {1'b0, xtal_reg})
                                  : cmsd_pkg::XTAL_W'(trial);
                    num_next = {num_reg[cmsd_pkg::VCO_W-2:0], ge};
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'(cmsd_pkg::VCO_W - 1)) begin
                        state_next = cmsd_pkg::VC_SCALE;
                    end
                end
                cmsd_pkg::VC_SCALE: begin
                    vco_next   = prod[cmsd_pkg::VCO_W-1:0];
                    state_next = cmsd_pkg::VC_IDLE;
                end
                default: begin
                    state_next = cmsd_pkg::VC_IDLE;
                end
            endcase
        end
    end

    assign busy = state_reg != cmsd_pkg::VC_IDLE;
    assign vco  = vco_reg;

    property p_count_bounded;
        @(posedge aclk) disable iff (!aresetn)
        state_reg == cmsd_pkg::VC_DIVIDE |-> cnt_reg < 5'(cmsd_pkg::VCO_W);
    endproperty
    a_count_bounded: assert property (p_count_bounded) else $error("divide count overrun");

    property p_start_busy;
        @(posedge aclk) disable iff (!aresetn)
        start |=> busy;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("start not taken");

    property p_vco_stable_idle;
        @(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == cmsd_pkg::VC_IDLE && $past(!start) |-> $stable(vco_reg);
    endproperty
    a_vco_stable_idle: assert property (p_vco_stable_idle) else $error("vco moved while idle");

endmodule

### rtl/clock_multisynth_divider_calc_unit.sv
// one request per cycle sustained while m_ready is held high and no vco update is running
// stages: check and select, 30 stage integer divider, fraction product,
// 20 stage fraction divider, word assembly into the output register
// a crystal register write recomputes the vco rate; no input beat is taken while it runs
// synchronous active-low reset empties the pipeline and restores crystal 25 MHz, 8 outputs
`timescale 1ns / 1ps
module clock_multisynth_divider_calc_unit #(
    parameter int OUTPUT_SLOTS = cmsd_pkg::OUTPUT_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cmsd_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cmsd_pkg::res_t   m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    logic [cmsd_pkg::XTAL_W-1:0] xtal_reg;
    logic [3:0]                  count_reg;
    logic                        vco_busy;
    logic [cmsd_pkg::VCO_W-1:0]  vco;
    logic                        xtal_wr;

    assign cfg_ready = 1'b1;
    assign xtal_wr   = cfg_valid && cfg_index == cmsd_pkg::CFG_CRYSTAL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xtal_reg  <= cmsd_pkg::XTAL_RESET;
            count_reg <= cmsd_pkg::COUNT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == cmsd_pkg::CFG_CRYSTAL) begin
                xtal_reg <= cfg_data[cmsd_pkg::XTAL_W-1:0];
            end else if (cfg_index == cmsd_pkg::CFG_OUTPUTS) begin
                count_reg <= cfg_data[3:0];
            end
        end
    end

    cmsd_vco_calc u_vco (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (xtal_wr),
        .xtal    (cfg_data[cmsd_pkg::XTAL_W-1:0]),
        .busy    (vco_busy),
        .vco     (vco)
    );

    // check and select stage
    logic                        d_v_reg;
    logic [cmsd_pkg::VCO_W-1:0]  d_num_reg;
    logic [cmsd_pkg::DEN_W-1:0]  d_den_reg;
    cmsd_pkg::meta_t             d_meta_reg;
    logic                        d_en;
    logic                        div1_in_ready;

    logic [cmsd_pkg::VCO_W-1:0]  d_num_next;
    logic [cmsd_pkg::DEN_W-1:0]  d_den_next;
    cmsd_pkg::meta_t             d_meta_next;

    always_comb begin
        logic [cmsd_pkg::FREQ_W-1:0] f;
        logic [7:0]                  dv;
        logic                        idx_ok, high, div_ok;
        logic [2:0]                  code;
        f      = s_data.target_frequency;
        dv     = s_data.output_divider;
        idx_ok = {1'b0, s_data.output_index} < count_reg
                 && 32'(s_data.output_index) < 32'(OUTPUT_SLOTS);
        high   = f > cmsd_pkg::FREQ_W'(vco[cmsd_pkg::VCO_W-1:3]);
        div_ok = dv != 8'd0 && (dv & (dv - 8'd1)) == 8'd0;
        code   = '0;
        for (int k = 0; k < 8; k++) begin
            if (dv[k]) begin
                code = 3'(k);
            end
        end
        d_meta_next               = '0;
        d_meta_next.register_base = cmsd_pkg::BASE_REG + {1'b0, s_data.output_index, 3'b000};
        priority if (!idx_ok) begin
            d_meta_next.status = cmsd_pkg::ST_BAD_OUT;
        end else if (xtal_reg == '0 || f == '0
                     || f < cmsd_pkg::FREQ_W'(vco[cmsd_pkg::VCO_W-1:11])
                     || f > cmsd_pkg::FREQ_MAX) begin
            d_meta_next.status = cmsd_pkg::ST_RANGE;
        end else if (high) begin
            if (f < cmsd_pkg::FREQ_GAP_TOP) begin
                d_meta_next.status = cmsd_pkg::ST_GAP;
            end else begin
                d_meta_next.use_pll_b = 1'b1;
                d_meta_next.div4_mode = cmsd_pkg::DIV4_ON;
            end
        end else if (!div_ok) begin
            d_meta_next.status = cmsd_pkg::ST_BAD_DIV;
        end else begin
            d_meta_next.r_div_code = code;
        end
        d_num_next = high ? {f, 2'b00} : vco;
        d_den_next = high ? {1'b0, xtal_reg} : f;
    end

    assign d_en    = !d_v_reg || div1_in_ready;
    assign s_ready = d_en && !vco_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (d_en) begin
            d_v_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_en) begin
            d_num_reg  <= d_num_next;
            d_den_reg  <= d_den_next;
            d_meta_reg <= d_meta_next;
        end
    end

    // integer quotient and remainder
    logic                        div1_out_valid;
    logic [cmsd_pkg::QUO_W-1:0]  div1_quo;
    logic [cmsd_pkg::DEN_W-1:0]  div1_rem;
    logic [cmsd_pkg::DEN_W-1:0]  div1_den;
    logic [$bits(cmsd_pkg::meta_t)-1:0] div1_side;
    logic                        p_en;

    cmsd_div_pipe #(
        .STEPS  (cmsd_pkg::QUO_W),
        .DEN_W  (cmsd_pkg::DEN_W),
        .SIDE_W ($bits(cmsd_pkg::meta_t))
    ) u_div_int (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_v_reg),
        .in_ready  (div1_in_ready),
        .in_rem    ('0),
        .in_bits   (d_num_reg),
        .in_den    (d_den_reg),
        .in_side   (d_meta_reg),
        .out_valid (div1_out_valid),
        .out_ready (p_en),
        .out_quo   (div1_quo),
        .out_rem   (div1_rem),
        .out_den   (div1_den),
        .out_side  (div1_side)
    );

    // fraction product: remainder times 2^20-1
    logic                        p_v_reg;
    logic [47:0]                 p_prod_reg;
    logic [cmsd_pkg::DEN_W-1:0]  p_den_reg;
    cmsd_pkg::frac_side_t        p_side_reg;
    logic                        div2_in_ready;

    assign p_en = !p_v_reg || div2_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (p_en) begin
            p_v_reg <= div1_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_en) begin
            p_prod_reg      <= {div1_rem, 20'd0} - {20'd0, div1_rem};
            p_den_reg       <= div1_den;
            p_side_reg.a    <= div1_quo;
            p_side_reg.meta <= cmsd_pkg::meta_t'(div1_side);
        end
    end

    // fraction numerator b
    logic                        div2_out_valid;
    logic [cmsd_pkg::FRAC_W-1:0] div2_quo;
    logic [$bits(cmsd_pkg::frac_side_t)-1:0] div2_side;
    logic                        m_en;

    cmsd_div_pipe #(
        .STEPS  (cmsd_pkg::FRAC_W),
        .DEN_W  (cmsd_pkg::DEN_W),
        .SIDE_W ($bits(cmsd_pkg::frac_side_t))
    ) u_div_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_v_reg),
        .in_ready  (div2_in_ready),
        .in_rem    (p_prod_reg[47:20]),
        .in_bits   (p_prod_reg[19:0]),
        .in_den    (p_den_reg),
        .in_side   (p_side_reg),
        .out_valid (div2_out_valid),
        .out_ready (m_en),
        .out_quo   (div2_quo),
        .out_rem   (),
        .out_den   (),
        .out_side  (div2_side)
    );

    // word assembly
    logic           m_v_reg;
    cmsd_pkg::res_t m_data_reg, m_data_next;

    always_comb begin
        cmsd_pkg::frac_side_t side;
        logic [26:0] x;
        logic [6:0]  q0, q;
        logic [20:0] s, rm;
        logic [19:0] t;
        logic [17:0] p1;
        logic [19:0] p2;
        side = cmsd_pkg::frac_side_t'(div2_side);
        x    = {div2_quo, 7'd0};
        q0   = x[26:20];
        s    = {1'b0, x[19:0]} + {14'd0, q0};
        if (s >= cmsd_pkg::FRAC_DEN) begin
            q  = q0 + 7'd1;
            rm = s - cmsd_pkg::FRAC_DEN;
        end else begin
            q  = q0;
            rm = s;
        end
        p2 = rm[19:0];
        t  = {side.a[12:0], 7'd0} + {13'd0, q};
        priority if (side.a > cmsd_pkg::A_LIMIT) begin
            p1 = cmsd_pkg::P1_MAX;
        end else if (t < cmsd_pkg::P1_OFFSET) begin
            p1 = '0;
        end else if (t - cmsd_pkg::P1_OFFSET > {2'b00, cmsd_pkg::P1_MAX}) begin
            p1 = cmsd_pkg::P1_MAX;
        end else begin
            p1 = 18'(t - cmsd_pkg::P1_OFFSET);
        end
        m_data_next               = '0;
        m_data_next.status        = side.meta.status;
        m_data_next.use_pll_b     = side.meta.use_pll_b;
        m_data_next.register_base = side.meta.register_base;
        m_data_next.r_div_code    = side.meta.r_div_code;
        m_data_next.div4_mode     = side.meta.div4_mode;
        if (side.meta.status == cmsd_pkg::ST_OK) begin
            if (side.meta.use_pll_b) begin
                m_data_next.ms_p3  = 20'd1;
                m_data_next.pll_p1 = p1;
                m_data_next.pll_p2 = p2;
            end else begin
                m_data_next.ms_p1 = p1;
                m_data_next.ms_p2 = p2;
                m_data_next.ms_p3 = cmsd_pkg::FRAC_DEN[19:0];
            end
        end
    end

    assign m_en = !m_v_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (m_en) begin
            m_v_reg <= div2_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_v_reg;
    assign m_data  = m_data_reg;

    property p_no_beat_while_busy;
        @(posedge aclk) disable iff (!aresetn)
        vco_busy |-> !s_ready;
    endproperty
    a_no_beat_while_busy: assert property (p_no_beat_while_busy)
        else $error("input beat taken during vco update");

    property p_error_zero;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != cmsd_pkg::ST_OK |->
            m_data.ms_p1 == '0 && m_data.ms_p3 == '0 && m_data.pll_p1 == '0
            && m_data.use_pll_b == 1'b0;
    endproperty
    a_error_zero: assert property (p_error_zero) else $error("error result carries words");

    property p_high_path_words;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.use_pll_b |->
            m_data.ms_p3 == 20'd1 && m_data.div4_mode == cmsd_pkg::DIV4_ON
            && m_data.r_div_code == '0;
    endproperty
    a_high_path_words: assert property (p_high_path_words) else $error("high path words wrong");

    property p_low_path_pll_zero;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.use_pll_b |-> m_data.pll_p1 == '0 && m_data.pll_p2 == '0;
    endproperty
    a_low_path_pll_zero: assert property (p_low_path_pll_zero) else $error("pll words on low path");

endmodule

### tb/tb_clock_multisynth_divider_calc_unit.sv
// self-checking testbench for clock_multisynth_divider_calc_unit: directed table, then random
// requests over several crystal and output-count settings, scored against an in-bench predictor
// depends on rtl/cmsd_pkg.sv and rtl/clock_multisynth_divider_calc_unit.sv
`timescale 1ns / 1ps
module tb_clock_multisynth_divider_calc_unit;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        cmsd_pkg::req_t req;
        bit             typed;
        cmsd_pkg::res_t res;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    cmsd_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    cmsd_pkg::res_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    longint unsigned crystal_hz;
    longint unsigned outputs_present;
    cmsd_pkg::res_t pending_words[$];
    int mismatches;
    int cycles;
    bit quiet;
    bit hold_request;

    clock_multisynth_divider_calc_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned vco_hz();
        if (crystal_hz == 0) return 0;
        return crystal_hz * ((64'd900000000 / crystal_hz) & 64'hFFFFFFFE);
    endfunction

    function automatic void divider_words(input longint unsigned num, input longint unsigned den,
                                          output logic [17:0] p1, output logic [19:0] p2);
        longint unsigned a, r, b, q, t;
        a = num / den;
        r = num % den;
        b = (64'd1048575 * r) / den;
        q = (64'd128 * b) / 64'd1048575;
        t = 64'd128 * a + q;
        if (a > 64'd4096) t = 64'd262143 + 64'd512;
        if (t < 64'd512) t = 0;
        else t = t - 64'd512;
        if (t > 64'd262143) t = 64'd262143;
        p1 = t[17:0];
        p2 = 20'(64'd128 * b - 64'd1048575 * q);
    endfunction

    function automatic cmsd_pkg::res_t predict_words(input cmsd_pkg::req_t r);
        cmsd_pkg::res_t o;
        longint unsigned f, vco;
        int k;
        bit pow2;
        o = '0;
        f = r.target_frequency;
        vco = vco_hz();
        o.register_base = 7'(42 + 8 * r.output_index);
        if (r.output_index >= outputs_present || r.output_index >= 8) begin
            o.status = cmsd_pkg::ST_BAD_OUT;
        end else if (crystal_hz == 0 || f == 0) begin
            o.status = cmsd_pkg::ST_RANGE;
        end else if (f < vco / 2048 || f > 64'd225000000) begin
            o.status = cmsd_pkg::ST_RANGE;
        end else if (f > vco / 8) begin
            if (f < 64'd150000000) begin
                o.status = cmsd_pkg::ST_GAP;
            end else begin
                divider_words(4 * f, crystal_hz, o.pll_p1, o.pll_p2);
                o.use_pll_b = 1'b1;
                o.ms_p3 = 20'd1;
                o.div4_mode = cmsd_pkg::DIV4_ON;
            end
        end else begin
            pow2 = 0;
            for (k = 0; k < 8; k++) begin
                if (r.output_divider == (8'd1 << k)) begin
                    o.r_div_code = 3'(k);
                    pow2 = 1;
                end
            end
            if (!pow2) begin
                o.status = cmsd_pkg::ST_BAD_DIV;
                o.r_div_code = 0;
            end else begin
                divider_words(vco, f, o.ms_p1, o.ms_p2);
                o.ms_p3 = 20'd1048575;
            end
        end
        return o;
    endfunction

    function automatic cmsd_pkg::res_t error_words(input logic [2:0] st, input logic [2:0] idx);
        cmsd_pkg::res_t o;
        o = '0;
        o.status = st;
        o.register_base = 7'(42 + 8 * idx);
        return o;
    endfunction

    task automatic send_request(input cmsd_pkg::req_t r, input bit typed,
                                input cmsd_pkg::res_t typed_res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(typed ? typed_res : predict_words(r));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        s_valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cmsd_pkg::CFG_CRYSTAL) crystal_hz = value & 32'h7FFFFFF;
        else if (idx == cmsd_pkg::CFG_OUTPUTS) outputs_present = value & 32'hF;
    endtask

    function automatic cmsd_pkg::req_t random_request();
        cmsd_pkg::req_t r;
        longint unsigned vco, lo, hi;
        int live;
        vco = vco_hz();
        live = (outputs_present > 8) ? 8 : int'(outputs_present);
        r.output_index = (live > 0 && $urandom_range(0, 9) < 8) ?
                         3'($urandom_range(0, live - 1)) : 3'($urandom_range(0, 7));
        lo = (vco / 2048 == 0) ? 1 : vco / 2048;
        hi = (vco / 8 < lo) ? lo : vco / 8;
        case ($urandom_range(0, 9))
            0: r.target_frequency = 28'($urandom);
            1, 2: r.target_frequency = 28'($urandom_range(150000000, 225000000));
            3: begin
                case ($urandom_range(0, 4))
                    0: r.target_frequency = 28'(lo + $urandom_range(0, 2) - 1);
                    1: r.target_frequency = 28'(hi + $urandom_range(0, 2) - 1);
                    2: r.target_frequency = 28'(150000000 + $urandom_range(0, 2) - 1);
                    3: r.target_frequency = 28'(225000000 + $urandom_range(0, 2) - 1);
                    default: r.target_frequency = 28'($urandom_range(hi, 150000000));
                endcase
            end
            default: r.target_frequency = 28'($urandom_range(int'(lo), int'(hi)));
        endcase
        r.output_divider = ($urandom_range(0, 9) < 8) ? 8'(1 << $urandom_range(0, 7))
                                                      : 8'($urandom);
        return r;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) send_request(random_request(), 0, '0);
    endtask

    // receiver side handshake
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_request = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                cmsd_pkg::res_t exp_w;
                exp_w = pending_words.pop_front();
                if (m_data !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_w, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_clock_multisynth_divider_calc_unit: errors");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        row_t rw;
        mismatches = 0;
        cycles = 0;
        quiet = 0;
        hold_request = 0;
        crystal_hz = 25000000;
        outputs_present = 8;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset settings: vco 900 MHz
        rows.push_back('{'{3'd0, 28'd0, 8'd1}, 1, error_words(cmsd_pkg::ST_RANGE, 3'd0)});
        rows.push_back('{'{3'd7, 28'hFFFFFFF, 8'd1}, 1, error_words(cmsd_pkg::ST_RANGE, 3'd7)});
        rows.push_back('{'{3'd1, 28'd439452, 8'd1}, 1, error_words(cmsd_pkg::ST_RANGE, 3'd1)});
        rows.push_back('{'{3'd2, 28'd225000001, 8'd2}, 1,
                         error_words(cmsd_pkg::ST_RANGE, 3'd2)});
        rows.push_back('{'{3'd3, 28'd120000000, 8'd1}, 1, error_words(cmsd_pkg::ST_GAP, 3'd3)});
        rows.push_back('{'{3'd4, 28'd149999999, 8'd0}, 1, error_words(cmsd_pkg::ST_GAP, 3'd4)});
        rows.push_back('{'{3'd5, 28'd10000000, 8'd3}, 1,
                         error_words(cmsd_pkg::ST_BAD_DIV, 3'd5)});
        rows.push_back('{'{3'd6, 28'd10000000, 8'd0}, 1,
                         error_words(cmsd_pkg::ST_BAD_DIV, 3'd6)});
        rows.push_back('{'{3'd0, 28'd10000000, 8'd255}, 1,
                         error_words(cmsd_pkg::ST_BAD_DIV, 3'd0)});
        rows.push_back('{'{3'd0, 28'd439453, 8'd128}, 0, '0});
        rows.push_back('{'{3'd1, 28'd112500000, 8'd1}, 0, '0});
        rows.push_back('{'{3'd2, 28'd112500001, 8'd1}, 0, '0});
        rows.push_back('{'{3'd3, 28'd150000000, 8'd7}, 0, '0});
        rows.push_back('{'{3'd4, 28'd225000000, 8'd1}, 0, '0});
        rows.push_back('{'{3'd5, 28'd187654321, 8'd64}, 0, '0});
        rows.push_back('{'{3'd6, 28'd10000000, 8'd2}, 0, '0});
        rows.push_back('{'{3'd7, 28'd1234567, 8'd4}, 0, '0});
        rows.push_back('{'{3'd0, 28'd33333333, 8'd8}, 0, '0});
        rows.push_back('{'{3'd1, 28'd7000000, 8'd16}, 0, '0});
        rows.push_back('{'{3'd2, 28'd999999, 8'd32}, 0, '0});
        foreach (rows[i]) begin
            rw = rows[i];
            send_request(rw.req, rw.typed, rw.res);
        end

        hold_request = 1;
        random_phase(100);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd10000000);
        random_phase(80);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd100000000 | ($urandom << 27));
        write_register(cmsd_pkg::CFG_OUTPUTS, 32'd3);
        random_phase(80);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd134217727);
        write_register(cmsd_pkg::CFG_OUTPUTS, 32'd1 | ($urandom << 4));
        random_phase(80);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd0);
        write_register(cmsd_pkg::CFG_OUTPUTS, 32'd8);
        random_phase(60);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd27000000);
        write_register(cmsd_pkg::CFG_OUTPUTS, 32'd15);
        random_phase(80);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd1);
        write_register(cmsd_pkg::CFG_OUTPUTS, 32'd0);
        random_phase(60);
        write_register(cmsd_pkg::CFG_OUTPUTS, 32'd8);
        random_phase(60);
        write_register(cmsd_pkg::CFG_CRYSTAL, 32'd25000000);
        quiet = 1;
        random_phase(150);
        s_valid <= 1'b0;

        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_clock_multisynth_divider_calc_unit: clean");
        end else begin
            $display("tb_clock_multisynth_divider_calc_unit: errors");
        end
        $finish;
    end
endmodule
